[hw/rtl/mtwt_pkg.sv]
// Shared types and constants for the multi-task watchdog table.
// Holds the item, result, command and status structs and the function codes.
// No dependencies.
`timescale 1ns / 1ps

package mtwt_pkg;

  localparam int DEF_MAX_TASKS = 16;
  localparam int MAX_RESULTS   = 16;
  localparam int RES_CNT_W     = $clog2(MAX_RESULTS + 1);

  localparam int FUNC_W = 2;
  localparam int ID_W   = 16;
  localparam int SLOT_W = 6;
  localparam int TIME_W = 32;
  localparam int PER_W  = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 1'b1;

  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd1000;
  localparam logic [PER_W-1:0]  PERIOD_RESET  = 16'd100;

  localparam logic [FUNC_W-1:0] FUNC_REG  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FEED = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd2;

  localparam logic [1:0] KIND_REG     = 2'd0;
  localparam logic [1:0] KIND_FEED    = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   task_id;
  } item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic              ok;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   timed_out_id;
    logic              last;
  } result_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic tick_due;
    logic feed_hit;
    logic done;
  } dp_status_t;

endpackage

[hw/rtl/multi_task_watchdog_table.sv]
// Top level of the multi-task watchdog table.
// Joins the mtwt_ctrl state machine and the mtwt_dp datapath; uses mtwt_pkg.
//
// Channel  Ports                                     Transfer
// item     start, busy, item                         start high and busy low
// result   result_valid, result                      every cycle result_valid is high
// config   cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid and cfg_ready high
//
// A register reply appears in the cycle after the transfer, and busy stays low.
// A feed or a due tick walks the table at one entry per cycle through the
// registered read port of the entry RAMs, with busy high.
// Timeout reports come out during the walk, the final one marked by last.
// Synchronous reset clears time, divider, fill count and active flags.
// Results are not held: each is shown for one cycle only.
`timescale 1ns / 1ps

module multi_task_watchdog_table
  import mtwt_pkg::*;
#(
  parameter int MAX_TASKS = DEF_MAX_TASKS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  item_t                 item,
  output result_t               result,
  output logic                  result_valid,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  mtwt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (item.func),
    .status(status),
    .cmd   (cmd),
    .busy  (busy)
  );

  mtwt_dp #(.MaxTasks(MAX_TASKS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .cmd         (cmd),
    .cfg_valid   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .status      (status),
    .result      (result),
    .result_valid(result_valid)
  );

endmodule

[hw/rtl/mtwt_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Used for the task id and feed time stores; no dependencies.
`timescale 1ns / 1ps

module mtwt_ram #(
  parameter int Width = 16,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/mtwt_ctrl.sv]
// Controller state machine for the watchdog table.
// Sequences table scans for feeds and timeout checks; uses mtwt_pkg.
`timescale 1ns / 1ps

module mtwt_ctrl
  import mtwt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [FUNC_W-1:0] func,
  input  dp_status_t        status,
  output ctrl_cmd_t         cmd,
  output logic              busy
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (func == FUNC_FEED || (func == FUNC_TICK && status.tick_due)) begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (status.done) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.step = 1'b1;
          if (status.feed_hit) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

[hw/rtl/mtwt_dp.sv]
// Datapath of the watchdog table: configuration, time base, entry stores and results.
// Uses mtwt_pkg and two mtwt_ram instances for task ids and feed times.
`timescale 1ns / 1ps

module mtwt_dp
  import mtwt_pkg::*;
#(
  parameter int MaxTasks = DEF_MAX_TASKS,
  localparam int IdxW = (MaxTasks > 1) ? $clog2(MaxTasks) : 1,
  localparam int CntW = $clog2(MaxTasks + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  item_t                 item,
  input  ctrl_cmd_t             cmd,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output dp_status_t            status,
  output result_t               result,
  output logic                  result_valid
);

  logic [TIME_W-1:0]    timeout;
  logic [PER_W-1:0]     period;
  logic [TIME_W-1:0]    now;
  logic [PER_W-1:0]     divider;
  logic [CntW-1:0]      used;
  logic [MaxTasks-1:0]  active;
  logic                 mode_feed;
  logic [ID_W-1:0]      task_id;
  logic [CntW-1:0]      rd_idx;
  logic                 chk_vld;
  logic [IdxW-1:0]      chk_idx;
  logic [RES_CNT_W-1:0] found;
  logic                 pend_vld;
  result_t              pend;
  result_t              result_next;
  logic                 result_valid_next;

  logic [ID_W-1:0]   id_rd;
  logic [TIME_W-1:0] fed_rd;
  logic [PER_W-1:0]  div_inc;
  logic [PER_W-1:0]  period_eff;
  logic [TIME_W-1:0] elapsed;
  logic              room;
  logic              reg_we;
  logic              tick_in;
  logic              feed_wr;
  logic              tick_hit;
  logic              match;
  logic [IdxW-1:0]   used_idx;
  result_t           report;

  assign used_idx   = used[IdxW-1:0];
  assign room       = (used < CntW'(MaxTasks));
  assign reg_we     = cmd.accept && (item.func == FUNC_REG) && room;
  assign tick_in    = cmd.accept && (item.func == FUNC_TICK);
  assign div_inc    = divider + 1'b1;
  assign period_eff = (period == '0) ? PER_W'(1) : period;
  assign elapsed    = now - fed_rd;

  assign match    = chk_vld && active[chk_idx] && (id_rd == task_id);
  assign tick_hit = chk_vld && !mode_feed && active[chk_idx] && (elapsed > timeout);
  assign feed_wr  = cmd.step && mode_feed && match;

  assign status.tick_due = (div_inc >= period_eff);
  assign status.feed_hit = mode_feed && match;
  assign status.done     = ((rd_idx >= used) && !chk_vld) ||
                           (!mode_feed && (found == RES_CNT_W'(MAX_RESULTS)));

  mtwt_ram #(.Width(ID_W), .Depth(MaxTasks)) u_id_ram (
    .clk  (clk),
    .we   (reg_we),
    .waddr(used_idx),
    .wdata(item.task_id),
    .raddr(rd_idx[IdxW-1:0]),
    .rdata(id_rd)
  );

  mtwt_ram #(.Width(TIME_W), .Depth(MaxTasks)) u_fed_ram (
    .clk  (clk),
    .we   (reg_we || feed_wr),
    .waddr(reg_we ? used_idx : chk_idx),
    .wdata(now),
    .raddr(rd_idx[IdxW-1:0]),
    .rdata(fed_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TIMEOUT_RESET;
      period  <= PERIOD_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TIMEOUT: timeout <= cfg_data;
        CFG_PERIOD:  period  <= cfg_data[PER_W-1:0];
        default:     timeout <= timeout;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now     <= '0;
      divider <= '0;
      used    <= '0;
      active  <= '0;
    end else begin
      if (tick_in) begin
        now     <= now + 1'b1;
        divider <= status.tick_due ? '0 : div_inc;
      end
      if (reg_we) begin
        used             <= used + 1'b1;
        active[used_idx] <= 1'b1;
      end
      if (cmd.step && tick_hit) begin
        active[chk_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_feed <= (item.func == FUNC_FEED);
      task_id   <= item.task_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chk_vld  <= 1'b0;
      pend_vld <= 1'b0;
      rd_idx   <= '0;
      found    <= '0;
    end else if (cmd.accept) begin
      chk_vld  <= 1'b0;
      pend_vld <= 1'b0;
      rd_idx   <= '0;
      found    <= '0;
    end else if (cmd.step) begin
      if (rd_idx < used) begin
        rd_idx  <= rd_idx + 1'b1;
        chk_vld <= 1'b1;
        chk_idx <= rd_idx[IdxW-1:0];
      end else begin
        chk_vld <= 1'b0;
      end
      if (tick_hit) begin
        pend_vld <= 1'b1;
        pend     <= report;
        found    <= found + 1'b1;
      end
    end
  end

  always_comb begin
    report.kind         = KIND_TIMEOUT;
    report.ok           = 1'b1;
    report.slot         = SLOT_W'(chk_idx);
    report.timed_out_id = id_rd;
    report.last         = 1'b0;
  end

  always_comb begin
    result_next       = pend;
    result_valid_next = 1'b0;
    if (cmd.accept && item.func == FUNC_REG) begin
      result_valid_next        = 1'b1;
      result_next.kind         = KIND_REG;
      result_next.ok           = room;
      result_next.slot         = room ? SLOT_W'(used) : '0;
      result_next.timed_out_id = item.task_id;
      result_next.last         = 1'b1;
    end else if (feed_wr) begin
      result_valid_next        = 1'b1;
      result_next.kind         = KIND_FEED;
      result_next.ok           = 1'b1;
      result_next.slot         = SLOT_W'(chk_idx);
      result_next.timed_out_id = task_id;
      result_next.last         = 1'b1;
    end else if (cmd.step && tick_hit) begin
      result_valid_next = pend_vld;
    end else if (cmd.finish) begin
      if (mode_feed) begin
        result_valid_next        = 1'b1;
        result_next.kind         = KIND_FEED;
        result_next.ok           = 1'b0;
        result_next.slot         = '0;
        result_next.timed_out_id = task_id;
        result_next.last         = 1'b1;
      end else begin
        result_valid_next = pend_vld;
        result_next.last  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= result_valid_next;
    end
    result <= result_next;
  end

endmodule

[hw/rtl/mtwt_checker.sv]
// Port-level checks for the multi-task watchdog table, bound to the top level.
// Uses mtwt_pkg for the struct types and codes.
`timescale 1ns / 1ps

module mtwt_checker
  import mtwt_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input item_t   item,
  input result_t result,
  input logic    result_valid
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !busy && !result_valid)
    else $error("busy or result strobe right after reset");

  a_reg_reply: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.func == FUNC_REG |=>
      result_valid && result.kind == KIND_REG && result.last)
    else $error("register transfer without a reply in the next cycle");

  a_feed_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.func == FUNC_FEED |=> busy)
    else $error("feed transfer did not start a table walk");

  a_feed_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind == KIND_FEED |-> result.last)
    else $error("feed reply not marked last");

  a_fail_slot: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.ok |-> result.slot == '0 && result.kind != KIND_TIMEOUT)
    else $error("failed reply with nonzero slot or failed timeout report");

endmodule

bind multi_task_watchdog_table mtwt_checker u_mtwt_checker (.*);

[tb/tb_multi_task_watchdog_table.sv]
// Self-checking testbench for multi_task_watchdog_table.
// Drives register, feed and tick commands and checks every result against a predictor.
// Depends on mtwt_pkg and the multi_task_watchdog_table RTL only.
`timescale 1ns / 1ps

module tb_multi_task_watchdog_table;
  import mtwt_pkg::*;

  localparam int TASKS = DEF_MAX_TASKS;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int REPORT_LIMIT = 10;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 36;
  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

  class watchdog_tracker;
    logic [TIME_W-1:0] timeout_ticks;
    logic [PER_W-1:0]  check_period;
    logic [ID_W-1:0]   ids [TASKS];
    logic [TIME_W-1:0] fed_at [TASKS];
    bit                active [TASKS];
    int                used;
    logic [TIME_W-1:0] now_ticks;
    logic [PER_W-1:0]  divider;
    result_t           due_results [$];
    int                mismatches;

    function new();
      timeout_ticks = TIMEOUT_RESET;
      check_period  = PERIOD_RESET;
      foreach (active[i]) active[i] = 1'b0;
      used       = 0;
      now_ticks  = '0;
      divider    = '0;
      mismatches = 0;
    endfunction

    function result_t make_result(logic [1:0] kind, logic ok, logic [SLOT_W-1:0] slot,
                                  logic [ID_W-1:0] id, logic last);
      result_t r;
      r.kind         = kind;
      r.ok           = ok;
      r.slot         = slot;
      r.timed_out_id = id;
      r.last         = last;
      return r;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_TIMEOUT: timeout_ticks = data;
        CFG_PERIOD:  check_period = data[PER_W-1:0];
        default: ;
      endcase
    endfunction

    function void predict_item(item_t it);
      int                hits [$];
      logic [PER_W-1:0]  period;
      case (it.func)
        FUNC_REG: begin
          if (used < TASKS) begin
            ids[used]    = it.task_id;
            fed_at[used] = now_ticks;
            active[used] = 1'b1;
            due_results.push_back(make_result(KIND_REG, 1'b1, SLOT_W'(used), it.task_id, 1'b1));
            used++;
          end else begin
            due_results.push_back(make_result(KIND_REG, 1'b0, '0, it.task_id, 1'b1));
          end
        end
        FUNC_FEED: begin
          for (int i = 0; i < used; i++)
            if (hits.size() == 0 && active[i] && ids[i] == it.task_id) hits.push_back(i);
          if (hits.size() != 0) begin
            fed_at[hits[0]] = now_ticks;
            due_results.push_back(make_result(KIND_FEED, 1'b1, SLOT_W'(hits[0]),
                                              it.task_id, 1'b1));
          end else begin
            due_results.push_back(make_result(KIND_FEED, 1'b0, '0, it.task_id, 1'b1));
          end
        end
        FUNC_TICK: begin
          now_ticks++;
          divider++;
          period = (check_period == '0) ? PER_W'(1) : check_period;
          if (divider >= period) begin
            divider = '0;
            for (int i = 0; i < used; i++) begin
              if (active[i] && hits.size() < MAX_RESULTS &&
                  (now_ticks - fed_at[i]) > timeout_ticks) begin
                active[i] = 1'b0;
                hits.push_back(i);
              end
            end
            foreach (hits[k])
              due_results.push_back(make_result(KIND_TIMEOUT, 1'b1, SLOT_W'(hits[k]),
                                                ids[hits[k]], k == hits.size() - 1));
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: kind %0d ok %0d slot %0d id %h last %0d",
                   got.kind, got.ok, got.slot, got.timed_out_id, got.last);
        return;
      end
      want = due_results.pop_front();
      if (got.kind !== want.kind || got.ok !== want.ok || got.slot !== want.slot ||
          got.timed_out_id !== want.timed_out_id || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("exp/act kind %0d/%0d ok %0d/%0d slot %0d/%0d id %h/%h last %0d/%0d",
                   want.kind, got.kind, want.ok, got.ok, want.slot, got.slot,
                   want.timed_out_id, got.timed_out_id, want.last, got.last);
      end
    endfunction

    function int outstanding();
      return due_results.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  item_t                 item = '0;
  result_t               result;
  logic                  result_valid;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_TIMEOUT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int unsigned           cycle_count = 0;
  watchdog_tracker       chk = new();

  multi_task_watchdog_table #(
    .MAX_TASKS(TASKS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .result(result),
    .result_valid(result_valid),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && result_valid) chk.compare_result(result);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic issue(input logic [FUNC_W-1:0] f, input logic [ID_W-1:0] id,
                       input int unsigned gap);
    item_t it;
    it.func    = f;
    it.task_id = id;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    chk.predict_item(it);
  endtask

  // Waits until every expected result is in, then lets an unproductive scan finish.
  task automatic settle();
    start <= 1'b0;
    while (chk.outstanding() != 0) @(posedge clk);
    repeat (TASKS + 4) @(posedge clk);
  endtask

  task automatic program_limits(input logic [TIME_W-1:0] to, input logic [PER_W-1:0] per);
    cfg_index <= CFG_TIMEOUT;
    cfg_data  <= to;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    chk.set_register(CFG_TIMEOUT, to);
    cfg_index <= CFG_PERIOD;
    cfg_data  <= CFG_DATA_W'(per);
    do @(posedge clk); while (!cfg_ready);
    chk.set_register(CFG_PERIOD, CFG_DATA_W'(per));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [TIME_W-1:0] to;
    logic [PER_W-1:0]  per;
    logic [FUNC_W-1:0] f;
    logic [ID_W-1:0]   id;
    logic [ID_W-1:0]   known_ids [$];
    int                pick;
    bit                calm;
    int unsigned       gap;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Empty table, ignored code, quiet tick, duplicate ids and feed misses.
    issue(FUNC_FEED, 16'h0000, $urandom_range(0, 17));
    issue(FUNC_SPARE, 16'hFFFF, $urandom_range(0, 17));
    issue(FUNC_TICK, 16'h0000, $urandom_range(0, 17));
    issue(FUNC_REG, 16'h0000, $urandom_range(0, 17));
    issue(FUNC_REG, 16'hFFFF, $urandom_range(0, 17));
    issue(FUNC_REG, 16'hFFFF, $urandom_range(0, 17));
    issue(FUNC_FEED, 16'hFFFF, $urandom_range(0, 17));
    issue(FUNC_FEED, 16'h5A5A, $urandom_range(0, 17));
    settle();

    // Timeout of one with a zero period: a scan on every tick, several reports at once.
    program_limits(32'd1, 16'd0);
    issue(FUNC_TICK, 16'hA5A5, 0);
    issue(FUNC_FEED, 16'h0000, $urandom_range(0, 17));
    issue(FUNC_TICK, 16'h0000, $urandom_range(0, 17));
    issue(FUNC_FEED, 16'hFFFF, $urandom_range(0, 17));
    issue(FUNC_TICK, 16'hFFFF, $urandom_range(0, 17));
    settle();

    // The period is lowered below the divider, so the next tick scans.
    program_limits(32'd2, 16'd8);
    issue(FUNC_REG, 16'h8001, $urandom_range(0, 17));
    repeat (5) issue(FUNC_TICK, 16'($urandom_range(0, 65535)), $urandom_range(0, 17));
    settle();
    program_limits(32'd2, 16'd3);
    issue(FUNC_TICK, 16'h7FFE, $urandom_range(0, 17));
    settle();

    known_ids = '{16'h0000, 16'hFFFF, 16'h8001};
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin to = 32'hFFFF_FFFF; per = 16'd1; end
        1: begin to = $urandom_range(8, 40); per = 16'($urandom_range(1, 4)); end
        2: begin to = 32'hFFFF_FFFE; per = 16'hFFFF; end
        3: begin to = $urandom_range(3, 12); per = 16'd0; end
        4: begin to = $urandom_range(20, 60); per = 16'($urandom_range(2, 9)); end
        5: begin to = 32'd1; per = 16'($urandom_range(1, 3)); end
        6: begin to = $urandom(); per = 16'($urandom_range(1, 65535)); end
        default: begin to = $urandom_range(10, 30); per = 16'd1; end
      endcase
      program_limits(to, per);
      calm = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        id = 16'($urandom_range(0, 65535));
        if (pick < 45) begin
          f = FUNC_TICK;
        end else if (pick < 80) begin
          f = FUNC_FEED;
          if ($urandom_range(0, 3) != 0)
            id = known_ids[$urandom_range(0, known_ids.size() - 1)];
        end else if (pick < 95) begin
          f = FUNC_REG;
          if ($urandom_range(0, 2) == 0)
            id = known_ids[$urandom_range(0, known_ids.size() - 1)];
          known_ids.push_back(id);
        end else begin
          f = FUNC_SPARE;
        end
        if (calm || $urandom_range(0, 2) == 0) gap = 0;
        else gap = $urandom_range(0, 17);
        issue(f, id, gap);
      end
      settle();
    end

    if (chk.outstanding() != 0)
      $display("%0d expected results never arrived", chk.outstanding());
    if (chk.mismatches == 0 && chk.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
